@@ rtl/dpls_pkg.sv @@
// Shared widths, constants, config register codes and sideband types of the point light shader.
package dpls_pkg;

  localparam int COORD_BITS = 10;
  localparam int NORM_W     = 16;
  localparam int COLOR_W    = 9;
  localparam int FALL_W     = 24;
  localparam int OUT_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // light minus point, and its squares and dot terms
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int D2_W   = 2 * DIFF_W;
  localparam int DOT_W  = DIFF_W + NORM_W + 1;

  // distance in Q.8 comes from the root of d2 * 2^16
  localparam int RAD_W  = D2_W + 16;
  localparam int ROOT_W = RAD_W / 2;

  // shared divider lanes: |dot| * 1024 / dist8 and dist8 * 256 / falloff
  localparam int DIVD_W = DOT_W - 1 + 10;
  localparam int DIVS_W = (FALL_W > ROOT_W) ? FALL_W : ROOT_W;
  localparam int QUO_W  = ROOT_W + 8;
  localparam int CMP_W  = DIVS_W + QUO_W;

  // cosine in Q.16 stays below 2^18 for any 16 bit normal
  localparam int COS_W  = 20;
  localparam int ATT_W  = QUO_W + 1;

  localparam logic [15:0] W_RED   = 16'd13763;
  localparam logic [15:0] W_GREEN = 16'd47186;
  localparam logic [15:0] W_BLUE  = 16'd4588;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIGHT_X     = 3'd0,
    REG_LIGHT_Y     = 3'd1,
    REG_LIGHT_RED   = 3'd2,
    REG_LIGHT_GREEN = 3'd3,
    REG_LIGHT_BLUE  = 3'd4,
    REG_FALLOFF     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic                    zero;
    logic signed [DOT_W-1:0] dot;
  } sqrt_side_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } div_side_t;

endpackage

@@ rtl/diffuse_point_light_shader_unit.sv @@
// Top level of the diffuse point light shader: config registers, front stages, pipeline.
// One word in and one word out per cycle while the output is not stalled, through three front
// stages for differences, squares and sums, one stage per bit of the 19 bit square root,
// one stage per bit of the 27 bit quotient in the two-lane divider, and seven stages for
// factor, color, luminance and the output register. All stages share one enable, so a stall
// at the output freezes the whole pipe and in_ready_o follows out_ready_i whenever a word is
// waiting. Config writes are always taken; change them only while the pipe is empty.
module diffuse_point_light_shader_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [dpls_pkg::COORD_BITS-1:0] point_x_i,
  input  logic signed [dpls_pkg::COORD_BITS-1:0] point_y_i,
  input  logic signed [dpls_pkg::NORM_W-1:0]     normal_x_i,
  input  logic signed [dpls_pkg::NORM_W-1:0]     normal_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [dpls_pkg::OUT_W-1:0]      shade_red_o,
  output logic signed [dpls_pkg::OUT_W-1:0]      shade_green_o,
  output logic signed [dpls_pkg::OUT_W-1:0]      shade_blue_o,
  output logic signed [dpls_pkg::OUT_W-1:0]      luminance_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dpls_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [dpls_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import dpls_pkg::*;

  logic signed [COORD_BITS-1:0] light_x_q, light_y_q;
  logic [COLOR_W-1:0]           light_red_q, light_green_q, light_blue_q;
  logic [FALL_W-1:0]            falloff_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q     <= COORD_BITS'(-60);
      light_y_q     <= COORD_BITS'(80);
      light_red_q   <= COLOR_W'(0);
      light_green_q <= COLOR_W'(256);
      light_blue_q  <= COLOR_W'(0);
      falloff_q     <= FALL_W'(1000000);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LIGHT_X:     light_x_q     <= cfg_data_i[COORD_BITS-1:0];
        REG_LIGHT_Y:     light_y_q     <= cfg_data_i[COORD_BITS-1:0];
        REG_LIGHT_RED:   light_red_q   <= cfg_data_i[COLOR_W-1:0];
        REG_LIGHT_GREEN: light_green_q <= cfg_data_i[COLOR_W-1:0];
        REG_LIGHT_BLUE:  light_blue_q  <= cfg_data_i[COLOR_W-1:0];
        REG_FALLOFF:     falloff_q     <= cfg_data_i[FALL_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en         = ~out_valid_o | out_ready_i;
  assign in_ready_o = en;

  // front: differences, products, sums
  logic [2:0]                          fv_q;
  logic signed [DIFF_W-1:0]            dx0_q, dy0_q, dx0_d, dy0_d;
  logic signed [NORM_W-1:0]            nx0_q, ny0_q;
  logic signed [D2_W-1:0]              sqx1_q, sqy1_q, sqx1_d, sqy1_d;
  logic signed [DIFF_W+NORM_W-1:0]     px1_q, py1_q, px1_d, py1_d;
  logic [D2_W-1:0]                     d2_2_q, d2_2_d;
  logic signed [DOT_W-1:0]             dot2_q, dot2_d;

  assign dx0_d  = DIFF_W'(light_x_q) - DIFF_W'(point_x_i);
  assign dy0_d  = DIFF_W'(light_y_q) - DIFF_W'(point_y_i);
  assign sqx1_d = dx0_q * dx0_q;
  assign sqy1_d = dy0_q * dy0_q;
  assign px1_d  = dx0_q * nx0_q;
  assign py1_d  = dy0_q * ny0_q;
  assign d2_2_d = sqx1_q + sqy1_q;
  assign dot2_d = DOT_W'(px1_q) + DOT_W'(py1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
    end else if (en) begin
      fv_q <= {fv_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx0_q  <= dx0_d;
      dy0_q  <= dy0_d;
      nx0_q  <= normal_x_i;
      ny0_q  <= normal_y_i;
      sqx1_q <= sqx1_d;
      sqy1_q <= sqy1_d;
      px1_q  <= px1_d;
      py1_q  <= py1_d;
      d2_2_q <= d2_2_d;
      dot2_q <= dot2_d;
    end
  end

  // distance in Q.8
  sqrt_side_t        sq_side_in, sq_side_out;
  logic              sq_valid;
  logic [ROOT_W-1:0] dist8;

  assign sq_side_in.zero = d2_2_q == '0;
  assign sq_side_in.dot  = dot2_q;

  dpls_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fv_q[2]),
    .rad_i   ({d2_2_q, 16'd0}),
    .side_i  (sq_side_in),
    .valid_o (sq_valid),
    .root_o  (dist8),
    .side_o  (sq_side_out)
  );

  // divider operands
  logic signed [DOT_W-1:0] dot_abs;
  logic [DIVD_W-1:0]       dvd_a, dvd_b;
  logic [DIVS_W-1:0]       dvs_a, dvs_b;
  div_side_t               dv_side_in, dv_side_out;
  logic                    dv_valid;
  logic [QUO_W-1:0]        quo_a, quo_b;

  assign dot_abs = sq_side_out.dot[DOT_W-1] ? -sq_side_out.dot : sq_side_out.dot;
  assign dvd_a   = {dot_abs[DOT_W-2:0], 10'd0};
  assign dvs_a   = sq_side_out.zero ? DIVS_W'(1) : DIVS_W'(dist8);
  assign dvd_b   = DIVD_W'({dist8, 8'd0});
  // zero falloff acts as one
  assign dvs_b   = (falloff_q == '0) ? DIVS_W'(1) : DIVS_W'(falloff_q);

  assign dv_side_in.zero = sq_side_out.zero;
  assign dv_side_in.neg  = sq_side_out.dot[DOT_W-1];

  dpls_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .dvd_a_i (dvd_a),
    .dvs_a_i (dvs_a),
    .dvd_b_i (dvd_b),
    .dvs_b_i (dvs_b),
    .side_i  (dv_side_in),
    .valid_o (dv_valid),
    .quo_a_o (quo_a),
    .quo_b_o (quo_b),
    .side_o  (dv_side_out)
  );

  dpls_mix u_mix (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (dv_valid),
    .quo_a_i       (quo_a),
    .quo_b_i       (quo_b),
    .side_i        (dv_side_out),
    .light_red_i   (light_red_q),
    .light_green_i (light_green_q),
    .light_blue_i  (light_blue_q),
    .valid_o       (out_valid_o),
    .shade_red_o   (shade_red_o),
    .shade_green_o (shade_green_o),
    .shade_blue_o  (shade_blue_o),
    .luminance_o   (luminance_o)
  );

endmodule

@@ rtl/dpls_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module dpls_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [dpls_pkg::RAD_W-1:0]    rad_i,
  input  dpls_pkg::sqrt_side_t          side_i,
  output logic                          valid_o,
  output logic [dpls_pkg::ROOT_W-1:0]   root_o,
  output dpls_pkg::sqrt_side_t          side_o
);
  import dpls_pkg::*;

  logic [ROOT_W-1:0] vld_q;
  logic [RAD_W:0]    rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  sqrt_side_t        side_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int I = ROOT_W - 1 - k;
    logic              vld_in;
    logic [RAD_W:0]    rem_in;
    logic [ROOT_W-1:0] root_in;
    sqrt_side_t        side_in;
    logic [RAD_W:0]    trial;
    logic              ge;
    logic [RAD_W:0]    rem_d;
    logic [ROOT_W-1:0] root_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = {1'b0, rad_i};
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
    end

    // (2R + 2^I) * 2^I; root bits sit above I so the OR is an add
    assign trial = ({{(RAD_W+1-ROOT_W){1'b0}}, root_in} << (I + 1))
                 | ((RAD_W+1)'(1) << (2 * I));
    assign ge    = rem_in >= trial;

    always_comb begin
      rem_d     = ge ? rem_in - trial : rem_in;
      root_d    = root_in;
      root_d[I] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

@@ rtl/dpls_div.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage per lane.
module dpls_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [dpls_pkg::DIVD_W-1:0]   dvd_a_i,
  input  logic [dpls_pkg::DIVS_W-1:0]   dvs_a_i,
  input  logic [dpls_pkg::DIVD_W-1:0]   dvd_b_i,
  input  logic [dpls_pkg::DIVS_W-1:0]   dvs_b_i,
  input  dpls_pkg::div_side_t           side_i,
  output logic                          valid_o,
  output logic [dpls_pkg::QUO_W-1:0]    quo_a_o,
  output logic [dpls_pkg::QUO_W-1:0]    quo_b_o,
  output dpls_pkg::div_side_t           side_o
);
  import dpls_pkg::*;

  logic [QUO_W-1:0]  vld_q;
  logic [DIVD_W-1:0] ra_q [QUO_W];
  logic [DIVD_W-1:0] rb_q [QUO_W];
  logic [DIVS_W-1:0] sa_q [QUO_W];
  logic [DIVS_W-1:0] sb_q [QUO_W];
  logic [QUO_W-1:0]  qa_q [QUO_W];
  logic [QUO_W-1:0]  qb_q [QUO_W];
  div_side_t         side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int I = QUO_W - 1 - k;
    logic              vld_in;
    logic [DIVD_W-1:0] ra_in, rb_in;
    logic [DIVS_W-1:0] sa_in, sb_in;
    logic [QUO_W-1:0]  qa_in, qb_in;
    div_side_t         side_in;
    logic [CMP_W-1:0]  ta, tb;
    logic              ge_a, ge_b;
    logic [DIVD_W-1:0] ra_d, rb_d;
    logic [QUO_W-1:0]  qa_d, qb_d;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign ra_in   = dvd_a_i;
      assign rb_in   = dvd_b_i;
      assign sa_in   = dvs_a_i;
      assign sb_in   = dvs_b_i;
      assign qa_in   = '0;
      assign qb_in   = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign ra_in   = ra_q[k-1];
      assign rb_in   = rb_q[k-1];
      assign sa_in   = sa_q[k-1];
      assign sb_in   = sb_q[k-1];
      assign qa_in   = qa_q[k-1];
      assign qb_in   = qb_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign ta   = CMP_W'(sa_in) << I;
    assign tb   = CMP_W'(sb_in) << I;
    assign ge_a = CMP_W'(ra_in) >= ta;
    assign ge_b = CMP_W'(rb_in) >= tb;

    // a taken trial never exceeds the remainder, so its low bits suffice
    always_comb begin
      ra_d     = ge_a ? ra_in - ta[DIVD_W-1:0] : ra_in;
      rb_d     = ge_b ? rb_in - tb[DIVD_W-1:0] : rb_in;
      qa_d     = qa_in;
      qb_d     = qb_in;
      qa_d[I]  = ge_a;
      qb_d[I]  = ge_b;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ra_q[k]   <= ra_d;
        rb_q[k]   <= rb_d;
        sa_q[k]   <= sa_in;
        sb_q[k]   <= sb_in;
        qa_q[k]   <= qa_d;
        qb_q[k]   <= qb_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_a_o = qa_q[QUO_W-1];
  assign quo_b_o = qb_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

@@ rtl/dpls_mix.sv @@
// Factor, per-channel color scaling, luminance and saturation; ends in the output register.
module dpls_mix (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [dpls_pkg::QUO_W-1:0]          quo_a_i,
  input  logic [dpls_pkg::QUO_W-1:0]          quo_b_i,
  input  dpls_pkg::div_side_t                 side_i,
  input  logic [dpls_pkg::COLOR_W-1:0]        light_red_i,
  input  logic [dpls_pkg::COLOR_W-1:0]        light_green_i,
  input  logic [dpls_pkg::COLOR_W-1:0]        light_blue_i,
  output logic                                valid_o,
  output logic signed [dpls_pkg::OUT_W-1:0]   shade_red_o,
  output logic signed [dpls_pkg::OUT_W-1:0]   shade_green_o,
  output logic signed [dpls_pkg::OUT_W-1:0]   shade_blue_o,
  output logic signed [dpls_pkg::OUT_W-1:0]   luminance_o
);
  import dpls_pkg::*;

  localparam int PROD_W = COS_W + ATT_W;
  localparam int FAC_W  = PROD_W - 16;
  localparam int CP_W   = FAC_W + COLOR_W + 1;
  localparam int CT_W   = CP_W - 16;
  localparam int LP_W   = OUT_W + 17;
  localparam int LS_W   = LP_W + 2;
  localparam int LT_W   = LS_W - 16;

  localparam logic signed [ATT_W-1:0]  ONE_Q16 = ATT_W'(65536);
  localparam logic signed [PROD_W-1:0] BIAS_P  = PROD_W'(65535);
  localparam logic signed [CP_W-1:0]   BIAS_C  = CP_W'(65535);
  localparam logic signed [LS_W-1:0]   BIAS_L  = LS_W'(65535);
  localparam logic signed [CT_W-1:0]   CT_HI   = CT_W'(2**(OUT_W-1) - 1);
  localparam logic signed [CT_W-1:0]   CT_LO   = -CT_W'(2**(OUT_W-1));
  localparam logic signed [LT_W-1:0]   LT_HI   = LT_W'(2**(OUT_W-1) - 1);
  localparam logic signed [LT_W-1:0]   LT_LO   = -LT_W'(2**(OUT_W-1));

  // product / 65536 toward zero, then clipped to the output field
  function automatic logic signed [OUT_W-1:0] chan_sat(input logic signed [CP_W-1:0] p);
    logic signed [CP_W-1:0] b;
    logic signed [CT_W-1:0] t;
    b = p + (p[CP_W-1] ? BIAS_C : '0);
    t = b[CP_W-1:16];
    if (t > CT_HI) begin
      return CT_HI[OUT_W-1:0];
    end else if (t < CT_LO) begin
      return CT_LO[OUT_W-1:0];
    end
    return t[OUT_W-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] lum_sat(input logic signed [LS_W-1:0] s);
    logic signed [LS_W-1:0] b;
    logic signed [LT_W-1:0] t;
    b = s + (s[LS_W-1] ? BIAS_L : '0);
    t = b[LS_W-1:16];
    if (t > LT_HI) begin
      return LT_HI[OUT_W-1:0];
    end else if (t < LT_LO) begin
      return LT_LO[OUT_W-1:0];
    end
    return t[OUT_W-1:0];
  endfunction

  logic [6:0] vld_q;

  // stage 1: signed cosine and attenuation
  logic                    zero1_q;
  logic signed [COS_W-1:0] cos1_q, cos1_d, cos_mag;
  logic signed [ATT_W-1:0] att1_q, att1_d;
  assign cos_mag = {1'b0, quo_a_i[COS_W-2:0]};
  assign cos1_d  = side_i.neg ? -cos_mag : cos_mag;
  assign att1_d  = ONE_Q16 - $signed({1'b0, quo_b_i});

  // stage 2: cosine times attenuation
  logic                     zero2_q;
  logic signed [PROD_W-1:0] prod2_q, prod2_d;
  assign prod2_d = cos1_q * att1_q;

  // stage 3: factor in Q.16, zero when the point sits on the light
  logic signed [FAC_W-1:0]  fac3_q, fac3_d;
  logic signed [PROD_W-1:0] prod_b;
  assign prod_b = prod2_q + (prod2_q[PROD_W-1] ? BIAS_P : '0);
  assign fac3_d = zero2_q ? '0 : prod_b[PROD_W-1:16];

  // stage 4: factor times each color
  logic signed [CP_W-1:0] pr4_q, pg4_q, pb4_q, pr4_d, pg4_d, pb4_d;
  assign pr4_d = fac3_q * $signed({1'b0, light_red_i});
  assign pg4_d = fac3_q * $signed({1'b0, light_green_i});
  assign pb4_d = fac3_q * $signed({1'b0, light_blue_i});

  // stage 5: clipped channels
  logic signed [OUT_W-1:0] cr5_q, cg5_q, cb5_q;

  // stage 6: weighted channels
  logic signed [OUT_W-1:0] cr6_q, cg6_q, cb6_q;
  logic signed [LP_W-1:0]  lr6_q, lg6_q, lb6_q, lr6_d, lg6_d, lb6_d;
  assign lr6_d = cr5_q * $signed({1'b0, W_RED});
  assign lg6_d = cg5_q * $signed({1'b0, W_GREEN});
  assign lb6_d = cb5_q * $signed({1'b0, W_BLUE});

  // stage 7: luminance sum, output register
  logic signed [LS_W-1:0] lsum;
  assign lsum = LS_W'(lr6_q) + LS_W'(lg6_q) + LS_W'(lb6_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero1_q       <= side_i.zero;
      cos1_q        <= cos1_d;
      att1_q        <= att1_d;
      zero2_q       <= zero1_q;
      prod2_q       <= prod2_d;
      fac3_q        <= fac3_d;
      pr4_q         <= pr4_d;
      pg4_q         <= pg4_d;
      pb4_q         <= pb4_d;
      cr5_q         <= chan_sat(pr4_q);
      cg5_q         <= chan_sat(pg4_q);
      cb5_q         <= chan_sat(pb4_q);
      cr6_q         <= cr5_q;
      cg6_q         <= cg5_q;
      cb6_q         <= cb5_q;
      lr6_q         <= lr6_d;
      lg6_q         <= lg6_d;
      lb6_q         <= lb6_d;
      shade_red_o   <= cr6_q;
      shade_green_o <= cg6_q;
      shade_blue_o  <= cb6_q;
      luminance_o   <= lum_sat(lsum);
    end
  end

  assign valid_o = vld_q[6];

endmodule
